// ----- hdl/rlf_pkg.sv -----
// ----------------------------------------------------------------------------
// rlf_pkg: shared types and constants of the reflector link controller
// Field widths, event and status codes, timer commands and the structs that
// pass between the control logic and the top level.
// ----------------------------------------------------------------------------
package rlf_pkg;

	localparam int TIMER_BITS_DEF = 20;
	localparam int CFG_W          = 20;
	localparam int ELAPSED_W      = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int S_TDATA_W      = 24;
	localparam int M_TDATA_W      = 8;

	localparam logic [CFG_W-1:0] RETRY_MS_RST   = CFG_W'(3000);
	localparam logic [CFG_W-1:0] TIMEOUT_MS_RST = CFG_W'(60000);

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_RETRY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		RT_LINK   = 2'd0,
		RT_UNLINK = 2'd1,
		RT_TICK   = 2'd2,
		RT_PACKET = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		PK_ACKN    = 3'd0,
		PK_NACK    = 3'd1,
		PK_DISC    = 3'd2,
		PK_PING    = 3'd3,
		PK_DATA    = 3'd4,
		PK_UNKNOWN = 3'd5
	} packet_kind_t;

	typedef enum logic [1:0] {
		SK_NONE       = 2'd0,
		SK_CONNECT    = 2'd1,
		SK_DISCONNECT = 2'd2,
		SK_PONG       = 2'd3
	} send_kind_t;

	typedef enum logic [2:0] {
		LS_NOT_LINKED = 3'd0,
		LS_LINKING    = 3'd1,
		LS_LINKED     = 3'd2,
		LS_UNLINKING  = 3'd3,
		LS_REJECTED   = 3'd4,
		LS_FAILED     = 3'd5
	} link_status_t;

	typedef enum logic [1:0] {
		TMR_HOLD,
		TMR_START,
		TMR_STOP,
		TMR_ADVANCE
	} tmr_cmd_t;

	typedef struct packed {
		req_type_t              req_type;
		logic [ELAPSED_W-1:0]   elapsed_ms;
		logic [2:0]             packet_kind;
		logic                   source_matches;
	} rlf_item_t;

	typedef struct packed {
		send_kind_t   send_kind;
		logic         frame_accepted;
		link_status_t link_status;
	} rlf_result_t;

endpackage

// ----- hdl/rlf_timer.sv -----
// ----------------------------------------------------------------------------
// rlf_timer: saturating millisecond timer
// Holds a running flag and an elapsed count. Start loads one, stop clears,
// advance adds the tick's milliseconds. A zero limit disables the timer.
// ----------------------------------------------------------------------------
module rlf_timer
	import rlf_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmr_cmd_t             cmd,
	input  logic [CFG_W-1:0]     limit,
	input  logic [ELAPSED_W-1:0] ms,
	output logic                 expired
);

	localparam int SUM_W = ((TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W) + 1;
	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'({TIMER_BITS{1'b1}});

	logic                  run_q;
	logic [TIMER_BITS-1:0] el_q;
	logic [SUM_W-1:0]      sum;
	logic [TIMER_BITS-1:0] el_adv;
	logic                  enabled;

	assign enabled = (limit != '0);
	assign sum     = SUM_W'(el_q) + SUM_W'(ms);
	assign el_adv  = (sum > SUM_MAX) ? {TIMER_BITS{1'b1}} : TIMER_BITS'(sum);

	// Expiry is judged on the count as it stands after this tick.
	assign expired = run_q && enabled && (CMP_W'(el_adv) >= CMP_W'(limit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			el_q  <= '0;
		end else begin
			unique case (cmd)
				TMR_HOLD: begin
				end
				TMR_START: begin
					if (enabled) begin
						run_q <= 1'b1;
						el_q  <= TIMER_BITS'(1);
					end
				end
				TMR_STOP: begin
					run_q <= 1'b0;
					el_q  <= '0;
				end
				TMR_ADVANCE: begin
					if (run_q && enabled) begin
						el_q <= el_adv;
					end
				end
			endcase
		end
	end

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (el_q == '0))
		else $error("stopped timer holds a non-zero count");

endmodule

// ----- hdl/rlf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rlf_ctrl: link state register and event decoding
// Applies one event per enabled cycle to the link status and both timers,
// and forms the result word for that event.
// ----------------------------------------------------------------------------
module rlf_ctrl
	import rlf_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  rlf_item_t        item,
	input  logic [CFG_W-1:0] retry_ms,
	input  logic [CFG_W-1:0] timeout_ms,
	output rlf_result_t      result
);

	link_status_t ls_q;
	link_status_t ls_d;
	tmr_cmd_t     retry_cmd;
	tmr_cmd_t     watch_cmd;
	logic         retry_exp;
	logic         watch_exp;
	send_kind_t   send;
	logic         accepted;
	logic         active;

	rlf_timer #(.TIMER_BITS(TIMER_BITS)) u_retry (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (retry_cmd),
		.limit   (retry_ms),
		.ms      (item.elapsed_ms),
		.expired (retry_exp)
	);

	rlf_timer #(.TIMER_BITS(TIMER_BITS)) u_watch (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (watch_cmd),
		.limit   (timeout_ms),
		.ms      (item.elapsed_ms),
		.expired (watch_exp)
	);

	assign active = (ls_q == LS_LINKING) || (ls_q == LS_LINKED) || (ls_q == LS_UNLINKING);

	always_comb begin
		ls_d      = ls_q;
		retry_cmd = TMR_HOLD;
		watch_cmd = TMR_HOLD;
		send      = SK_NONE;
		accepted  = 1'b0;
		if (fire) begin
			unique case (item.req_type)
				RT_LINK: begin
					ls_d      = LS_LINKING;
					send      = SK_CONNECT;
					retry_cmd = TMR_START;
					watch_cmd = TMR_START;
				end
				RT_UNLINK: begin
					if ((ls_q == LS_LINKED) || (ls_q == LS_LINKING)) begin
						ls_d      = LS_UNLINKING;
						send      = SK_DISCONNECT;
						retry_cmd = TMR_START;
						watch_cmd = TMR_START;
					end
				end
				RT_TICK: begin
					retry_cmd = TMR_ADVANCE;
					watch_cmd = TMR_ADVANCE;
					if (retry_exp) begin
						if (ls_q == LS_LINKING) begin
							send      = SK_CONNECT;
							retry_cmd = TMR_START;
						end else if (ls_q == LS_UNLINKING) begin
							send      = SK_DISCONNECT;
							retry_cmd = TMR_START;
						end else begin
							retry_cmd = TMR_STOP;
						end
					end
					// Supervision expiry wins over a retry restart in the same tick,
					// but a message already resent is still reported.
					if (watch_exp) begin
						if ((ls_q == LS_LINKING) || (ls_q == LS_LINKED)) begin
							ls_d = LS_FAILED;
						end else if (ls_q == LS_UNLINKING) begin
							ls_d = LS_NOT_LINKED;
						end
						retry_cmd = TMR_STOP;
						watch_cmd = TMR_STOP;
					end
				end
				RT_PACKET: begin
					if (active && item.source_matches) begin
						unique case (item.packet_kind)
							PK_ACKN: begin
								ls_d      = LS_LINKED;
								watch_cmd = TMR_START;
								retry_cmd = TMR_STOP;
							end
							PK_NACK: begin
								ls_d      = LS_REJECTED;
								watch_cmd = TMR_STOP;
								retry_cmd = TMR_STOP;
							end
							PK_DISC: begin
								ls_d      = LS_NOT_LINKED;
								watch_cmd = TMR_STOP;
								retry_cmd = TMR_STOP;
							end
							PK_PING: begin
								if (ls_q == LS_LINKED) begin
									watch_cmd = TMR_START;
									send      = SK_PONG;
								end
							end
							PK_DATA: begin
								if (ls_q == LS_LINKED) begin
									watch_cmd = TMR_START;
									accepted  = 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q <= LS_NOT_LINKED;
		end else begin
			ls_q <= ls_d;
		end
	end

	assign result.send_kind      = send;
	assign result.frame_accepted = accepted;
	assign result.link_status    = ls_d;

endmodule

// ----- hdl/reflector_link_fsm_top.sv -----
// ----------------------------------------------------------------------------
// reflector_link_fsm_top: client link controller for a reflector
// Stream wrapper with input and output registers around the link control
// logic, plus the two timer configuration registers.
// ----------------------------------------------------------------------------
// Each input word is one event: a link request, an unlink request, a tick of
// elapsed milliseconds or a received packet that has already been classified.
// Every event produces exactly one result word giving the control message to
// transmit, whether a data frame is passed on, and the link status after the
// event. The block takes one word per clock cycle while the master side does
// not stall; a result word passes through the input register and then the
// output register before it is presented on the master side. The rate is set
// by the link status and timer registers, which are read and updated once per
// event, so each event sees everything its predecessor left behind. When the
// master side stalls, the output register holds its word and the input
// register still takes one more word before the slave side pushes back. The
// retry and supervision periods are written through the configuration port,
// which is always ready; writes are meant to happen only while no event is in
// flight. A period of zero disables that timer. Timer counts saturate at
// 2^TIMER_BITS - 1.
// ----------------------------------------------------------------------------
module reflector_link_fsm_top
	import rlf_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write channel; index 0 is the retry period, 1 the timeout.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// Event words in.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// elapsed_ms [15:0], packet_kind [18:16], source_matches [19], zero [23:20]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// req_type [1:0]
	input  logic [1:0]           s_tuser,
	// Result words out.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// send_kind [1:0], frame_accepted [2], link_status [5:3], zero [7:6]
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic [CFG_W-1:0] retry_ms_q;
	logic [CFG_W-1:0] timeout_ms_q;

	logic        vld_s1;
	rlf_item_t   item_s1;
	logic        vld_s2;
	rlf_result_t res_s2;
	rlf_result_t result;
	logic        s_accept;
	logic        fire;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_ms_q   <= RETRY_MS_RST;
			timeout_ms_q <= TIMEOUT_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IDX_RETRY:   retry_ms_q   <= cfg_data;
				CFG_IDX_TIMEOUT: timeout_ms_q <= cfg_data;
			endcase
		end
	end

	// An event is processed when it sits in the input register and the output
	// register is empty or being emptied in the same cycle.
	assign fire     = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || fire;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_accept) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.req_type       <= req_type_t'(s_tuser);
			item_s1.elapsed_ms     <= s_tdata[ELAPSED_W-1:0];
			item_s1.packet_kind    <= s_tdata[ELAPSED_W+2:ELAPSED_W];
			item_s1.source_matches <= s_tdata[ELAPSED_W+3];
		end
	end

	rlf_ctrl #(.TIMER_BITS(TIMER_BITS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.retry_ms   (retry_ms_q),
		.timeout_ms (timeout_ms_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {2'b00, res_s2.link_status, res_s2.frame_accepted, res_s2.send_kind};

	// A frame is only ever passed on while the link is up.
	a_frame_linked: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.frame_accepted) |-> (res_s2.link_status == LS_LINKED))
		else $error("frame accepted outside the linked state");

	// Pong answers a ping only on an established link.
	a_pong_linked: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && (res_s2.send_kind == SK_PONG)) |-> (res_s2.link_status == LS_LINKED))
		else $error("pong sent outside the linked state");

	// A result word only appears after an event was processed.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s2) |-> $past(fire))
		else $error("result word appeared without a processed event");

	// An event that cannot move on stays put in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !fire) |=> (vld_s1 && $stable(item_s1)))
		else $error("stalled event lost or altered");

endmodule

// ----- sim/tb_reflector_link_fsm_top.sv -----
// ----------------------------------------------------------------------------
// tb_reflector_link_fsm_top: self-checking bench for the reflector link block
// Drives event words through the slave stream and keeps its own model of the
// link status and both timers. Every result word is compared field by field
// with the model's prediction. The run covers directed link sequences, zero
// and extreme periods, timer saturation, and random traffic under several
// sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_reflector_link_fsm_top;
	import rlf_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam logic [TIMER_BITS_DEF-1:0] TIMER_MAX = {TIMER_BITS_DEF{1'b1}};
	localparam logic [CFG_W-1:0] PERIOD_MAX = {CFG_W{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Idling percentages for the current phase.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	int unsigned n_errors = 0;
	int unsigned quiet_cycles = 0;

	// Result words predicted for accepted events, oldest first.
	rlf_result_t due_results[$];
	rlf_result_t due_word;

	// Shadow copy of the block's state and period registers.
	link_status_t              link_state;
	logic                      retry_run;
	logic [TIMER_BITS_DEF-1:0] retry_count;
	logic                      watch_run;
	logic [TIMER_BITS_DEF-1:0] watch_count;
	logic [CFG_W-1:0]          retry_period;
	logic [CFG_W-1:0]          timeout_period;

	reflector_link_fsm_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Link model
	// ------------------------------------------------------------------

	// A timer restarts its count at one, but only when its period is set.
	function automatic void arm_retry();
		if (retry_period != '0) begin
			retry_run = 1'b1;
			retry_count = 1;
		end
	endfunction

	function automatic void arm_watch();
		if (timeout_period != '0) begin
			watch_run = 1'b1;
			watch_count = 1;
		end
	endfunction

	function automatic void clear_timers();
		retry_run = 1'b0;
		retry_count = '0;
		watch_run = 1'b0;
		watch_count = '0;
	endfunction

	function automatic logic [TIMER_BITS_DEF-1:0] timer_add(
		logic [TIMER_BITS_DEF-1:0] count, logic [ELAPSED_W-1:0] ms);
		logic [TIMER_BITS_DEF:0] sum;
		sum = {1'b0, count} + ms;
		return (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_BITS_DEF-1:0];
	endfunction

	// Applies one event to the shadow state and returns the result word the
	// block must produce for it.
	function automatic rlf_result_t link_step(rlf_item_t it);
		rlf_result_t r;
		logic        active;
		r.send_kind = SK_NONE;
		r.frame_accepted = 1'b0;
		case (it.req_type)
		RT_LINK: begin
			link_state = LS_LINKING;
			r.send_kind = SK_CONNECT;
			arm_retry();
			arm_watch();
		end
		RT_UNLINK: begin
			if (link_state == LS_LINKED || link_state == LS_LINKING) begin
				link_state = LS_UNLINKING;
				r.send_kind = SK_DISCONNECT;
				arm_retry();
				arm_watch();
			end
		end
		RT_TICK: begin
			// The retry timer goes first, so a resend is still reported when
			// supervision expires in the same tick.
			if (retry_run && retry_period != '0) begin
				retry_count = timer_add(retry_count, it.elapsed_ms);
				if (retry_count >= retry_period) begin
					if (link_state == LS_LINKING) begin
						r.send_kind = SK_CONNECT;
						arm_retry();
					end else if (link_state == LS_UNLINKING) begin
						r.send_kind = SK_DISCONNECT;
						arm_retry();
					end else begin
						retry_run = 1'b0;
						retry_count = '0;
					end
				end
			end
			if (watch_run && timeout_period != '0) begin
				watch_count = timer_add(watch_count, it.elapsed_ms);
				if (watch_count >= timeout_period) begin
					if (link_state == LS_LINKING || link_state == LS_LINKED)
						link_state = LS_FAILED;
					else if (link_state == LS_UNLINKING)
						link_state = LS_NOT_LINKED;
					clear_timers();
				end
			end
		end
		default: begin
			active = (link_state == LS_LINKING || link_state == LS_LINKED ||
				link_state == LS_UNLINKING);
			if (active && it.source_matches) begin
				case (it.packet_kind)
				PK_ACKN: begin
					arm_watch();
					retry_run = 1'b0;
					retry_count = '0;
					link_state = LS_LINKED;
				end
				PK_NACK: begin
					clear_timers();
					link_state = LS_REJECTED;
				end
				PK_DISC: begin
					clear_timers();
					link_state = LS_NOT_LINKED;
				end
				PK_PING: begin
					if (link_state == LS_LINKED) begin
						arm_watch();
						r.send_kind = SK_PONG;
					end
				end
				PK_DATA: begin
					if (link_state == LS_LINKED) begin
						arm_watch();
						r.frame_accepted = 1'b1;
					end
				end
				default: ;
				endcase
			end
		end
		endcase
		r.link_status = link_state;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic rlf_item_t make_word(req_type_t req, logic [ELAPSED_W-1:0] ms,
		logic [2:0] kind, logic src_match);
		rlf_item_t it;
		it.req_type = req;
		it.elapsed_ms = ms;
		it.packet_kind = kind;
		it.source_matches = src_match;
		return it;
	endfunction

	// Tick lengths: mostly short, so that small periods expire now and then,
	// with the occasional full-range value.
	function automatic logic [ELAPSED_W-1:0] random_ms();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return ELAPSED_W'($urandom_range(255));
		else if (pick < 90)
			return ELAPSED_W'($urandom_range(4095));
		return ELAPSED_W'($urandom);
	endfunction

	// A random event. Packets mostly come from the linked reflector and favour
	// the kinds that keep a link alive, so that the linked state is reached
	// often; the rest is foreign or unknown traffic.
	function automatic rlf_item_t random_word();
		rlf_item_t   it;
		int unsigned pick;
		it.elapsed_ms = random_ms();
		it.source_matches = ($urandom_range(99) < 85);
		pick = $urandom_range(99);
		if (pick < 20)
			it.packet_kind = PK_ACKN;
		else if (pick < 28)
			it.packet_kind = PK_NACK;
		else if (pick < 36)
			it.packet_kind = PK_DISC;
		else if (pick < 58)
			it.packet_kind = PK_PING;
		else if (pick < 86)
			it.packet_kind = PK_DATA;
		else
			it.packet_kind = 3'($urandom_range(PK_UNKNOWN, 7));
		pick = $urandom_range(99);
		if (pick < 10)
			it.req_type = RT_LINK;
		else if (pick < 17)
			it.req_type = RT_UNLINK;
		else if (pick < 52)
			it.req_type = RT_TICK;
		else
			it.req_type = RT_PACKET;
		return it;
	endfunction

	// Presents one event word and holds it until the block takes it. The valid
	// is left high so that back-to-back words need no gap.
	task automatic send_word(rlf_item_t it);
		s_tvalid <= 1'b1;
		s_tuser <= it.req_type;
		s_tdata <= {4'b0000, it.source_matches, it.packet_kind, it.elapsed_ms};
		do @(posedge clk); while (!s_tready);
		due_results.push_back(link_step(it));
	endtask

	task automatic send_with_gaps(rlf_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		send_word(it);
	endtask

	// Stops sending and waits until every predicted word has come back, then lets
	// the two pipeline registers settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_period(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_IDX_RETRY)
			retry_period = value;
		else
			timeout_period = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_periods(logic [CFG_W-1:0] retry, logic [CFG_W-1:0] timeout);
		wait_drained();
		write_period(CFG_IDX_RETRY, retry);
		write_period(CFG_IDX_TIMEOUT, timeout);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Link, resend, the packet kinds when linked, failure by silence,
	// rejection, unlink with resend, acknowledge while unlinking, and a
	// disconnect from the reflector. Runs on the reset periods.
	task automatic test_link_sequence();
		send_word(make_word(RT_LINK, 16'hFFFF, PK_UNKNOWN, 1'b1));
		send_word(make_word(RT_TICK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_TICK, 16'd2999, PK_ACKN, 1'b0));
		send_word(make_word(RT_PACKET, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_PACKET, 16'hFFFF, PK_ACKN, 1'b1));
		send_word(make_word(RT_PACKET, 16'd0, PK_PING, 1'b1));
		send_word(make_word(RT_PACKET, 16'd0, PK_DATA, 1'b1));
		send_word(make_word(RT_PACKET, 16'd0, PK_UNKNOWN, 1'b1));
		send_word(make_word(RT_PACKET, 16'd0, 3'd7, 1'b1));
		send_word(make_word(RT_TICK, 16'hFFFF, PK_DISC, 1'b1));
		send_word(make_word(RT_PACKET, 16'd0, PK_ACKN, 1'b1));
		send_word(make_word(RT_LINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_PACKET, 16'd0, PK_NACK, 1'b1));
		send_word(make_word(RT_UNLINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_LINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_UNLINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_TICK, 16'd2999, PK_ACKN, 1'b0));
		send_word(make_word(RT_PACKET, 16'd0, PK_ACKN, 1'b1));
		send_word(make_word(RT_UNLINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_TICK, 16'hFFFF, PK_ACKN, 1'b0));
		send_word(make_word(RT_LINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_PACKET, 16'd0, PK_DISC, 1'b1));
		send_word(make_word(RT_PACKET, 16'd0, PK_PING, 1'b1));
		send_word(make_word(RT_PACKET, 16'd0, 3'd6, 1'b1));
	endtask

	// A zero period disables its timer entirely; a period of one expires on
	// the very next tick, with the resend reported alongside the failure.
	task automatic test_period_extremes();
		set_periods('0, '0);
		send_word(make_word(RT_LINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_TICK, 16'hFFFF, PK_ACKN, 1'b0));
		send_word(make_word(RT_UNLINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_TICK, 16'hFFFF, PK_ACKN, 1'b0));
		set_periods(CFG_W'(1), CFG_W'(1));
		send_word(make_word(RT_LINK, 16'd0, PK_ACKN, 1'b0));
		send_word(make_word(RT_TICK, 16'd0, PK_ACKN, 1'b0));
	endtask

	// With both periods at their maximum the counts only reach them by
	// saturating, which takes seventeen full-length ticks.
	task automatic test_timer_saturation();
		set_periods(PERIOD_MAX, PERIOD_MAX);
		send_word(make_word(RT_LINK, 16'd0, PK_ACKN, 1'b0));
		repeat (17)
			send_word(make_word(RT_TICK, 16'hFFFF, PK_ACKN, 1'b0));
	endtask

	// Random traffic under one idling pattern. Halfway through, the sender
	// holds off until every result has come back.
	task automatic run_random_phase(int unsigned n_words, int unsigned idle_pct,
		int unsigned stall_share);
		send_idle_pct = idle_pct;
		stall_pct = stall_share;
		for (int unsigned i = 0; i < n_words; i++) begin
			send_with_gaps(random_word());
			if (i == n_words / 2)
				wait_drained();
		end
		wait_drained();
	endtask

	task automatic test_random_no_idling();
		set_periods(CFG_W'($urandom_range(1, 300)), CFG_W'($urandom_range(1, 3000)));
		run_random_phase(200, 0, 0);
	endtask

	task automatic test_random_sender_idle();
		set_periods(CFG_W'(1), PERIOD_MAX);
		run_random_phase(200, 63, 0);
	endtask

	task automatic test_random_receiver_stall();
		set_periods('0, CFG_W'($urandom_range(1, 2000)));
		run_random_phase(200, 0, 63);
	endtask

	task automatic test_random_both_idle();
		set_periods(RETRY_MS_RST, TIMEOUT_MS_RST);
		run_random_phase(200, 9, 9);
	endtask

	// ------------------------------------------------------------------
	// Result checking, receiver stalls and the watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$error("result word %h with no event outstanding", m_tdata);
				n_errors++;
			end else begin
				due_word = due_results.pop_front();
				if (m_tdata[1:0] !== due_word.send_kind) begin
					$error("send_kind: expected %0d, got %0d",
						due_word.send_kind, m_tdata[1:0]);
					n_errors++;
				end
				if (m_tdata[2] !== due_word.frame_accepted) begin
					$error("frame_accepted: expected %0d, got %0d",
						due_word.frame_accepted, m_tdata[2]);
					n_errors++;
				end
				if (m_tdata[5:3] !== due_word.link_status) begin
					$error("link_status: expected %0d, got %0d",
						due_word.link_status, m_tdata[5:3]);
					n_errors++;
				end
			end
		end
	end

	// Any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_reflector_link_fsm_top: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		link_state = LS_NOT_LINKED;
		retry_period = RETRY_MS_RST;
		timeout_period = TIMEOUT_MS_RST;
		clear_timers();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_link_sequence();
		test_period_extremes();
		test_timer_saturation();
		test_random_no_idling();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();

		wait_drained();
		repeat (8) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d result words never arrived", due_results.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("tb_reflector_link_fsm_top: done, clean");
		else
			$display("tb_reflector_link_fsm_top: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/rlf_pkg.sv
hdl/rlf_timer.sv
hdl/rlf_ctrl.sv
hdl/reflector_link_fsm_top.sv
sim/tb_reflector_link_fsm_top.sv
